[src/tw_pkg.sv]
// Package for the text window glyph writer: widths, codes, register map,
// structs shared between the front end, the job queue and the command back end.
// No dependencies.
package tw_pkg;

    // Framebuffer geometry
    localparam int BYTES_PER_LINE = 80;
    localparam int GLYPH_ROWS     = 16;

    // Field widths
    localparam int CHAR_W    = 8;
    localparam int COL_W     = 7;
    localparam int LINE_W    = 5;
    localparam int VOFF_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int GROW_W    = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

    localparam logic [VOFF_W-1:0] LINE_BYTES_V = VOFF_W'(BYTES_PER_LINE * GLYPH_ROWS);
    localparam logic [VOFF_W-1:0] LINE_STEP_V  = VOFF_W'(BYTES_PER_LINE);
    localparam logic [GROW_W-1:0] GROW_LAST    = GROW_W'(GLYPH_ROWS - 1);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);

    // Command kinds
    localparam logic OP_COPY  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // APB register map
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IW  = 3;
    localparam logic [REG_IW-1:0] REG_WIN_COL    = 3'd0;
    localparam logic [REG_IW-1:0] REG_WIN_ROW    = 3'd1;
    localparam logic [REG_IW-1:0] REG_WIN_WIDTH  = 3'd2;
    localparam logic [REG_IW-1:0] REG_WIN_HEIGHT = 3'd3;
    localparam logic [REG_IW-1:0] REG_FONT_BASE  = 3'd4;

    // Reset values
    localparam logic [COL_W-1:0]  RST_WIN_WIDTH  = COL_W'(40);
    localparam logic [LINE_W-1:0] RST_WIN_HEIGHT = LINE_W'(30);

    // Job queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [COL_W-1:0]  win_col;
        logic [LINE_W-1:0] win_row;
        logic [COL_W-1:0]  win_width;
        logic [LINE_W-1:0] win_height;
        logic [ADDR_W-1:0] font_base;
    } t_cfg;

    typedef struct packed {
        logic              do_copy;
        logic              do_clear;
        logic [VOFF_W-1:0] copy_voff;
        logic [ADDR_W-1:0] font_addr;
        logic [VOFF_W-1:0] clear_voff;
        logic [COL_W-1:0]  cursor_col;
        logic [LINE_W-1:0] cursor_row;
    } t_job;

    typedef struct packed {
        logic              op_kind;
        logic [VOFF_W-1:0] vram_offset;
        logic [ADDR_W-1:0] font_addr;
        logic [COL_W-1:0]  cursor_col;
        logic [LINE_W-1:0] cursor_row;
        logic              last;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_COPY,
        BK_CLEAR
    } t_bk_state;

endpackage

[src/tw_if.sv]
// Valid/ready channel interfaces for characters in and commands out.
// Depends on tw_pkg.
interface tw_char_if import tw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tw_cmd_if import tw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op_kind;
    logic [VOFF_W-1:0] vram_offset;
    logic [ADDR_W-1:0] font_addr;
    logic [COL_W-1:0]  cursor_col;
    logic [LINE_W-1:0] cursor_row;
    logic              last;

    modport source (output valid, output op_kind, output vram_offset, output font_addr,
                    output cursor_col, output cursor_row, output last, input ready);
    modport sink   (input valid, input op_kind, input vram_offset, input font_addr,
                    input cursor_col, input cursor_row, input last, output ready);
endinterface

[src/tw_regs.sv]
// APB register file holding the window geometry and font base.
// Depends on tw_pkg.
module tw_regs import tw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg              r_cfg;
    logic              wr_en;
    logic [REG_IW-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_col    <= '0;
            r_cfg.win_row    <= '0;
            r_cfg.win_width  <= RST_WIN_WIDTH;
            r_cfg.win_height <= RST_WIN_HEIGHT;
            r_cfg.font_base  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIN_COL:    r_cfg.win_col    <= pwdata[COL_W-1:0];
                REG_WIN_ROW:    r_cfg.win_row    <= pwdata[LINE_W-1:0];
                REG_WIN_WIDTH:  r_cfg.win_width  <= pwdata[COL_W-1:0];
                REG_WIN_HEIGHT: r_cfg.win_height <= pwdata[LINE_W-1:0];
                REG_FONT_BASE:  r_cfg.font_base  <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIN_COL:    prdata = APB_DW'(r_cfg.win_col);
            REG_WIN_ROW:    prdata = APB_DW'(r_cfg.win_row);
            REG_WIN_WIDTH:  prdata = APB_DW'(r_cfg.win_width);
            REG_WIN_HEIGHT: prdata = APB_DW'(r_cfg.win_height);
            REG_FONT_BASE:  prdata = APB_DW'(r_cfg.font_base);
            default:        prdata = '0;
        endcase
    end

endmodule

[src/tw_front.sv]
// Front end: takes characters, keeps the cursor and turns each one but a
// bare newline into one job (copy and/or clear) for the queue. Depends on tw_pkg, tw_if.
module tw_front import tw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tw_char_if.sink   i_char,
    input  t_cfg      i_cfg,
    input  logic      i_q_ready,
    output logic      o_push,
    output t_job      o_job
);

    logic [COL_W-1:0]  r_col,  n_col;
    logic [LINE_W-1:0] r_line, n_line;

    logic              accept;
    logic              is_nl;
    logic              wrap;
    logic              clr;
    logic [COL_W-1:0]  col_a,  col_b;
    logic [LINE_W-1:0] line_a, line_b;
    logic [LINE_W:0]   row_sum;

    assign i_char.ready = i_q_ready;
    assign accept       = i_char.valid && i_q_ready;

    always_comb begin
        is_nl  = (i_char.char_code == NEWLINE_CODE);
        col_a  = is_nl ? '0 : r_col + COL_W'(1);
        line_a = is_nl ? r_line + LINE_W'(1) : r_line;
        wrap   = (col_a >= i_cfg.win_width);
        col_b  = wrap ? '0 : col_a;
        line_b = wrap ? line_a + LINE_W'(1) : line_a;
        clr    = (line_b >= i_cfg.win_height);
        n_col  = clr ? '0 : col_b;
        n_line = clr ? '0 : line_b;
    end

    always_comb begin
        row_sum           = {1'b0, i_cfg.win_row} + {1'b0, r_line};
        o_job.do_copy     = !is_nl;
        o_job.do_clear    = clr;
        o_job.copy_voff   = VOFF_W'(row_sum) * LINE_BYTES_V + VOFF_W'(i_cfg.win_col)
                            + VOFF_W'(r_col);
        o_job.font_addr   = i_cfg.font_base
                            + ADDR_W'(i_char.char_code) * ADDR_W'(GLYPH_ROWS);
        o_job.clear_voff  = VOFF_W'(i_cfg.win_row) * LINE_BYTES_V
                            + VOFF_W'(i_cfg.win_col);
        o_job.cursor_col  = n_col;
        o_job.cursor_row  = n_line;
        // a bare newline only moves the cursor
        o_push            = accept && (!is_nl || clr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

endmodule

[src/tw_queue.sv]
// Short job queue between the front end and the command back end.
// Depends on tw_pkg.
module tw_queue import tw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;
    logic            full;

    assign full    = (r_count == Q_CW'(Q_DEPTH));
    assign o_ready = !full;
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from empty queue");

endmodule

[src/tw_back.sv]
// Back end: sequences each job into glyph-row copy commands, a window clear or
// both, through an output register. Depends on tw_pkg, tw_if.
module tw_back import tw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    tw_cmd_if.source  o_cmd
);

    t_bk_state         r_state, n_state;
    t_job              r_job;
    logic [GROW_W-1:0] r_idx;
    logic [VOFF_W-1:0] r_voff;
    logic [ADDR_W-1:0] r_faddr;
    t_cmd              r_out;
    logic              r_out_valid;

    logic              advance;
    logic              emit;
    logic              copy_last;
    logic              item_last;
    t_cmd              item;
    t_bk_state         load_state;

    assign advance    = !r_out_valid || o_cmd.ready;
    assign copy_last  = (r_idx == GROW_LAST);
    assign load_state = i_job.do_copy ? BK_COPY : BK_CLEAR;

    // outputs of the sequencer
    always_comb begin
        emit      = advance && (r_state != BK_IDLE);
        item_last = (r_state == BK_CLEAR) || (copy_last && !r_job.do_clear);
        o_pop     = i_q_valid && ((r_state == BK_IDLE) || (emit && item_last));

        item.cursor_col = r_job.cursor_col;
        item.cursor_row = r_job.cursor_row;
        item.last       = item_last;
        if (r_state == BK_CLEAR) begin
            item.op_kind     = OP_CLEAR;
            item.vram_offset = r_job.clear_voff;
            item.font_addr   = '0;
        end else begin
            item.op_kind     = OP_COPY;
            item.vram_offset = r_voff;
            item.font_addr   = r_faddr;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (o_pop) n_state = load_state;
            end
            BK_COPY: begin
                if (emit && copy_last) begin
                    if (r_job.do_clear) n_state = BK_CLEAR;
                    else if (o_pop)     n_state = load_state;
                    else                n_state = BK_IDLE;
                end
            end
            BK_CLEAR: begin
                if (emit) n_state = o_pop ? load_state : BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job payload and running addresses
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_idx   <= '0;
            r_voff  <= i_job.copy_voff;
            r_faddr <= i_job.font_addr;
        end else if (emit && (r_state == BK_COPY)) begin
            r_idx   <= r_idx + GROW_W'(1);
            r_voff  <= r_voff + LINE_STEP_V;
            r_faddr <= r_faddr + ADDR_W'(1);
        end
        if (emit) begin
            r_out <= item;
        end
    end

    assign o_cmd.valid       = r_out_valid;
    assign o_cmd.op_kind     = r_out.op_kind;
    assign o_cmd.vram_offset = r_out.vram_offset;
    assign o_cmd.font_addr   = r_out.font_addr;
    assign o_cmd.cursor_col  = r_out.cursor_col;
    assign o_cmd.cursor_row  = r_out.cursor_row;
    assign o_cmd.last        = r_out.last;

    a_clear_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.op_kind == OP_CLEAR)) |-> r_out.last)
        else $error("clear command not marked last");

    a_job_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_cmd.ready && !r_out.last) |=> r_out_valid)
        else $error("gap inside a character's command burst");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |-> !emit)
        else $error("command emitted with no job");

endmodule

[src/text_window_glyph_writer.sv]
// Text window glyph writer. Each printed character becomes sixteen glyph-row
// copy commands, one per clock from the back-end sequencer while the command
// output is not stalled, followed by a window clear when the cursor runs off
// the bottom; that sequencer sets the sustained rate. A bare newline produces
// no command. A two-entry job queue lets the character input run ahead of the
// command output. Configure only while idle; registers sit at 4*index on APB.
module text_window_glyph_writer import tw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tw_char_if.sink           i_char,
    tw_cmd_if.source          o_cmd,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    t_job push_job, pop_job;
    logic push, q_ready, q_valid, pop;

    tw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_cfg     (cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    tw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    tw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (pop_job),
        .o_pop     (pop),
        .o_cmd     (o_cmd)
    );

endmodule

[tb/text_window_glyph_writer_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for text_window_glyph_writer: directed script, then random
// window settings and characters, with every command compared against a local predictor.
// Depends on tw_pkg, tw_if and the writer RTL.
module text_window_glyph_writer_test;
    import tw_pkg::*;

    typedef enum logic {STEP_CHAR, STEP_REG} t_step_kind;

    typedef struct packed {
        t_step_kind        kind;
        logic [REG_IW-1:0] reg_idx;
        logic [31:0]       value;
        logic              checked;
        t_cmd              want;
    } t_step;

    localparam logic [REG_IW-1:0] REG_NONE = '1;
    localparam t_cmd NO_CMD        = '0;
    localparam int   RANDOM_CHARS  = 305;
    localparam int   DRAIN_CYCLES  = 24;
    localparam int   TAIL_CYCLES   = 40;
    localparam int   CYCLE_LIMIT   = 600000;
    localparam logic [31:0] CHAR_NL = 32'(NEWLINE_CODE);

    localparam logic [REG_IW-1:0] REG_LIST [5] =
        '{REG_WIN_COL, REG_WIN_ROW, REG_WIN_WIDTH, REG_WIN_HEIGHT, REG_FONT_BASE};
    localparam logic [31:0] REG_TOP [5] =
        '{(1 << COL_W) - 1, (1 << LINE_W) - 1, (1 << COL_W) - 1, (1 << LINE_W) - 1,
          32'hFFFF_FFFF};

    // Only the final command of a checked row is typed in; the rest come from the predictor.
    localparam t_step SCRIPT [27] = '{
        '{STEP_CHAR, REG_NONE, 32'h00, 1'b1, '{OP_COPY, 16'd1200, 32'd15, 7'd1, 5'd0, 1'b1}},
        '{STEP_CHAR, REG_NONE, 32'hff, 1'b1, '{OP_COPY, 16'd1201, 32'd4095, 7'd2, 5'd0, 1'b1}},
        '{STEP_CHAR, REG_NONE, CHAR_NL, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h41, 1'b1, '{OP_COPY, 16'd2480, 32'd1055, 7'd1, 5'd1, 1'b1}},
        '{STEP_REG, REG_WIN_HEIGHT, 32'd1, 1'b0, NO_CMD},
        '{STEP_REG, REG_WIN_WIDTH, 32'd2, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h42, 1'b1, '{OP_CLEAR, 16'd0, 32'd0, 7'd0, 5'd0, 1'b1}},
        '{STEP_REG, REG_WIN_WIDTH, 32'd0, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h58, 1'b1, '{OP_CLEAR, 16'd0, 32'd0, 7'd0, 5'd0, 1'b1}},
        '{STEP_CHAR, REG_NONE, CHAR_NL, 1'b1, '{OP_CLEAR, 16'd0, 32'd0, 7'd0, 5'd0, 1'b1}},
        '{STEP_REG, REG_WIN_HEIGHT, 32'd0, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h7e, 1'b1, '{OP_CLEAR, 16'd0, 32'd0, 7'd0, 5'd0, 1'b1}},
        '{STEP_REG, REG_WIN_HEIGHT, 32'd2, 1'b0, NO_CMD},
        '{STEP_REG, REG_WIN_WIDTH, 32'd3, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h30, 1'b1, '{OP_COPY, 16'd1200, 32'd783, 7'd1, 5'd0, 1'b1}},
        '{STEP_CHAR, REG_NONE, CHAR_NL, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h31, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h32, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'h33, 1'b1, '{OP_CLEAR, 16'd0, 32'd0, 7'd0, 5'd0, 1'b1}},
        '{STEP_REG, REG_WIN_COL, 32'd127, 1'b0, NO_CMD},
        '{STEP_REG, REG_WIN_ROW, 32'd31, 1'b0, NO_CMD},
        '{STEP_REG, REG_FONT_BASE, 32'hFFFF_FFFF, 1'b0, NO_CMD},
        '{STEP_REG, REG_WIN_WIDTH, 32'd127, 1'b0, NO_CMD},
        '{STEP_REG, REG_WIN_HEIGHT, 32'd31, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, 32'hff, 1'b1, '{OP_COPY, 16'd41007, 32'd4094, 7'd1, 5'd0, 1'b1}},
        '{STEP_REG, REG_WIN_HEIGHT, 32'd1, 1'b0, NO_CMD},
        '{STEP_CHAR, REG_NONE, CHAR_NL, 1'b1, '{OP_CLEAR, 16'd39807, 32'd0, 7'd0, 5'd0, 1'b1}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    tw_char_if chars ();
    tw_cmd_if  cmds ();

    text_window_glyph_writer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chars),
        .o_cmd   (cmds),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the window settings and the cursor
    logic [COL_W-1:0]  win_col;
    logic [LINE_W-1:0] win_row;
    logic [COL_W-1:0]  win_width;
    logic [LINE_W-1:0] win_height;
    logic [ADDR_W-1:0] font_base;
    logic [COL_W-1:0]  cur_col;
    logic [LINE_W-1:0] cur_line;

    t_cmd pending_cmds[$];
    int   errors = 0;
    int   chars_sent = 0;
    int   cmds_checked = 0;
    int   clears_checked = 0;
    int   settings_used = 0;
    int   cycles = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycles, pending_cmds.size());
            $display("text_window_glyph_writer_test NOT OK");
            $finish;
        end
    end

    // Command sink back-pressure: mostly ready, short stalls, the odd long one
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            cmds.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm || $urandom_range(9) < 7) begin
            cmds.ready <= 1'b1;
        end else begin
            cmds.ready <= 1'b0;
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(3);
        end
    end

    always @(posedge i_clk) begin : cmd_check
        t_cmd want;
        if (i_rst_n && cmds.valid && cmds.ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected command: op_kind %0d vram_offset %0d font_addr %0h",
                       cmds.op_kind, cmds.vram_offset, cmds.font_addr);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (want.op_kind == OP_CLEAR) clears_checked++;
                if (cmds.op_kind !== want.op_kind) begin
                    $error("op_kind: expected %0d, got %0d", want.op_kind, cmds.op_kind);
                    errors++;
                end
                if (cmds.vram_offset !== want.vram_offset) begin
                    $error("vram_offset: expected %0d, got %0d",
                           want.vram_offset, cmds.vram_offset);
                    errors++;
                end
                if (cmds.font_addr !== want.font_addr) begin
                    $error("font_addr: expected %0h, got %0h", want.font_addr, cmds.font_addr);
                    errors++;
                end
                if (cmds.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d",
                           want.cursor_col, cmds.cursor_col);
                    errors++;
                end
                if (cmds.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d",
                           want.cursor_row, cmds.cursor_row);
                    errors++;
                end
                if (cmds.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, cmds.last);
                    errors++;
                end
            end
        end
    end

    // Work out the commands one character produces and advance the cursor
    task automatic predict_glyph_cmds(input logic [CHAR_W-1:0] code);
        logic [31:0] origin;
        logic [31:0] glyph;
        t_cmd        cmd;
        t_cmd        step_cmds[$];
        if (code == NEWLINE_CODE) begin
            cur_col = '0;
            cur_line = cur_line + LINE_W'(1);
        end else begin
            origin = (32'(win_row) + 32'(cur_line)) * 32'(BYTES_PER_LINE * GLYPH_ROWS)
                     + 32'(win_col) + 32'(cur_col);
            glyph = font_base + 32'(code) * 32'(GLYPH_ROWS);
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                cmd = '0;
                cmd.op_kind = OP_COPY;
                cmd.vram_offset = VOFF_W'(origin + 32'(r * BYTES_PER_LINE));
                cmd.font_addr = glyph + 32'(r);
                step_cmds.push_back(cmd);
            end
            cur_col = cur_col + COL_W'(1);
        end
        if (cur_col >= win_width) begin
            cur_line = cur_line + LINE_W'(1);
            cur_col = '0;
        end
        if (cur_line >= win_height) begin
            cmd = '0;
            cmd.op_kind = OP_CLEAR;
            cmd.vram_offset = VOFF_W'(32'(win_row) * 32'(BYTES_PER_LINE * GLYPH_ROWS)
                                      + 32'(win_col));
            step_cmds.push_back(cmd);
            cur_line = '0;
            cur_col = '0;
        end
        foreach (step_cmds[k]) begin
            step_cmds[k].cursor_col = cur_col;
            step_cmds[k].cursor_row = cur_line;
            step_cmds[k].last = (k == step_cmds.size() - 1);
            pending_cmds.push_back(step_cmds[k]);
        end
    endtask

    // Leaves valid high on return so a back-to-back beat can follow in the same step
    task automatic send_char(input logic [CHAR_W-1:0] code);
        int pick;
        int gap;
        pick = $urandom_range(99);
        gap = calm ? 0 : (pick < 60) ? 0 : (pick < 92) ? $urandom_range(3, 1)
                                                        : $urandom_range(40, 10);
        if (gap != 0) begin
            chars.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        chars.valid <= 1'b1;
        chars.char_code <= code;
        do @(posedge i_clk); while (!(chars.valid && chars.ready));
        predict_glyph_cmds(code);
        chars_sent++;
    endtask

    task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_WIN_COL:    win_col = value[COL_W-1:0];
            REG_WIN_ROW:    win_row = value[LINE_W-1:0];
            REG_WIN_WIDTH:  win_width = value[COL_W-1:0];
            REG_WIN_HEIGHT: win_height = value[LINE_W-1:0];
            REG_FONT_BASE:  font_base = value;
            default: ;
        endcase
    endtask

    // Drop valid, wait out the commands, then let the design settle before returning
    task automatic wait_for_drain();
        chars.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] draw_setting(input logic [31:0] top);
        case ($urandom_range(5))
            0: return '0;
            1: return top;
            2, 3: return 32'($urandom_range(4));
            default: return 32'($urandom_range(top));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned nl_pct;
        int unsigned run_len;
        int          random_sent;
        bit          busy;
        logic [CHAR_W-1:0] code;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        chars.valid = 1'b0;
        chars.char_code = '0;
        cmds.ready = 1'b0;
        win_col = '0;
        win_row = '0;
        win_width = RST_WIN_WIDTH;
        win_height = RST_WIN_HEIGHT;
        font_base = '0;
        cur_col = '0;
        cur_line = '0;
        random_sent = 0;
        busy = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == STEP_REG) begin
                if (busy) begin
                    wait_for_drain();
                    busy = 1'b0;
                    settings_used++;
                end
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].value);
            end else begin
                send_char(SCRIPT[i].value[CHAR_W-1:0]);
                busy = 1'b1;
                if (SCRIPT[i].checked)
                    pending_cmds[pending_cmds.size() - 1] = SCRIPT[i].want;
            end
        end

        while (random_sent < RANDOM_CHARS) begin
            wait_for_drain();
            settings_used++;
            calm = ($urandom_range(3) == 0);
            foreach (REG_LIST[k])
                if ($urandom_range(3) != 0) write_reg(REG_LIST[k], draw_setting(REG_TOP[k]));
            nl_pct = $urandom_range(50, 5);
            run_len = $urandom_range(60, 15);
            // keep the total at the planned character count
            if (run_len > int'(RANDOM_CHARS - random_sent))
                run_len = int'(RANDOM_CHARS - random_sent);
            repeat (run_len) begin
                code = ($urandom_range(99) < nl_pct) ? NEWLINE_CODE
                                                     : CHAR_W'($urandom_range(255));
                send_char(code);
                random_sent++;
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d characters under %0d window settings, %0d commands checked",
                 chars_sent, settings_used, cmds_checked);
        $display("%0d window clears among them, %0d mismatches", clears_checked, errors);
        if (errors == 0) begin
            $display("text_window_glyph_writer_test OK");
        end else begin
            $display("text_window_glyph_writer_test NOT OK");
        end
        $finish;
    end
endmodule

[filelist.f]
src/tw_pkg.sv
src/tw_if.sv
src/tw_regs.sv
src/tw_front.sv
src/tw_queue.sv
src/tw_back.sv
src/text_window_glyph_writer.sv
tb/text_window_glyph_writer_test.sv
